FILE: hw/rtl/wvt_pkg.sv
// Shared constants, command and register codes, and divider interface types
// for the window-to-viewport transform. No dependencies.
package wvt_pkg;

  // Fraction bits of the fixed-point scale
  localparam int unsigned FRAC_BITS = 14;

  // Divider widths: dividend magnitude up to 32 + FRAC_BITS bits, divisor 32 bits
  localparam int unsigned NUM_W = 32 + FRAC_BITS;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  localparam logic [31:0] SCALE_ONE  = 32'd1 << FRAC_BITS;
  localparam logic [15:0] EDGE_RESET = 16'd16384;

  // Commands
  localparam logic [1:0] CMD_MAP   = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_SIZE  = 2'd2;
  localparam logic [1:0] CMD_INV   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_WORLD_LEFT   = 3'd0;
  localparam logic [2:0] REG_WORLD_TOP    = 3'd1;
  localparam logic [2:0] REG_WORLD_RIGHT  = 3'd2;
  localparam logic [2:0] REG_WORLD_BOTTOM = 3'd3;
  localparam logic [2:0] REG_VIEW_LEFT    = 3'd4;
  localparam logic [2:0] REG_VIEW_TOP     = 3'd5;
  localparam logic [2:0] REG_VIEW_RIGHT   = 3'd6;
  localparam logic [2:0] REG_VIEW_BOTTOM  = 3'd7;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: hw/rtl/wvt_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on wvt_pkg for widths and the request/response structs.
module wvt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wvt_pkg::div_req_t req_i,
  output wvt_pkg::div_rsp_t rsp_o
);

  logic [wvt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [wvt_pkg::NUM_W-1:0] quo_q, quo_d;
  logic [wvt_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [wvt_pkg::DEN_W-1:0] den_q, den_d;
  logic [wvt_pkg::DEN_W:0]   shifted;
  logic                      fits;

  always_comb begin
    shifted = {rem_q, quo_q[wvt_pkg::NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (req_i.start) begin
      cnt_d  = wvt_pkg::CNT_W'(wvt_pkg::NUM_W);
      busy_d = 1'b1;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      quo_d = {quo_q[wvt_pkg::NUM_W-2:0], fits};
      rem_d = fits ? wvt_pkg::DEN_W'(shifted - {1'b0, den_q})
                   : shifted[wvt_pkg::DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wvt_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: hw/rtl/window_viewport_transform.sv
// Window-to-viewport transform: sequencer, shared multiplier and register state.
// Depends on wvt_pkg and wvt_div.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o    | command_i, x_in_i, y_in_i
//   out     | output    | out_valid_o / out_stall_i  | out_x_o, out_y_o, start_x_o/_y_o
//   cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One item at a time; both axes go through the same multiplier and divider in turn.
// Place and size use only the multiplier; inverse divides up to once per axis and map
// up to twice, on the one-bit-per-cycle divider. A finished item waits in the output
// register while the next item is taken. No clearing pass after reset; a stalled
// output holds the sequencer only at its final step.
module window_viewport_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] x_in_i,
  input  logic [15:0] y_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [15:0] start_x_o,
  output logic [15:0] start_y_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPAN  = 4'd1;
  localparam logic [3:0] S_SDIV  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_ODIV  = 4'd5;
  localparam logic [3:0] S_OWAIT = 4'd6;
  localparam logic [3:0] S_FMUL  = 4'd7;
  localparam logic [3:0] S_FADD  = 4'd8;
  localparam logic [3:0] S_IDIV  = 4'd9;
  localparam logic [3:0] S_IWAIT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // control and architectural state
  logic [3:0]  state_q, state_d;
  logic        axis_q, axis_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] world_left_q, world_left_d, world_top_q, world_top_d;
  logic [15:0] world_right_q, world_right_d, world_bottom_q, world_bottom_d;
  logic [15:0] view_left_q, view_left_d, view_top_q, view_top_d;
  logic [15:0] view_right_q, view_right_d, view_bottom_q, view_bottom_d;
  logic [31:0] scale_x_q, scale_x_d, scale_y_q, scale_y_d;
  logic [31:0] offset_x_q, offset_x_d, offset_y_q, offset_y_d;
  logic [15:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;

  // payload
  logic [1:0]         cmd_q, cmd_d;
  logic [15:0]        x_q, x_d, y_q, y_d;
  logic               sign_q, sign_d;
  logic [32:0]        p1_q, p1_d;
  logic signed [48:0] prod_q, prod_d;
  logic [31:0]        res_x_q, res_x_d, res_y_q, res_y_d;
  logic [31:0]        out_x_q, out_x_d, out_y_q, out_y_d;
  logic [15:0]        start_x_q, start_x_d, start_y_q, start_y_d;

  // datapath
  logic [15:0]        sel_wl, sel_wh, sel_vl, sel_vh;
  logic [16:0]        wspan, vspan, wmag, vmag;
  logic [15:0]        cur_c;
  logic [31:0]        cur_scale, cur_offset, smag;
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic [32:0]        onum, omag;
  logic signed [48:0] fsh;
  logic [31:0]        fsum;
  logic [33:0]        idiff, imag;
  logic [31:0]        q32, qs, qscale;
  logic               in_acc, out_load;

  wvt_pkg::div_req_t div_req;
  wvt_pkg::div_rsp_t div_rsp;

  wvt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    sel_wl = axis_q ? world_top_q    : world_left_q;
    sel_wh = axis_q ? world_bottom_q : world_right_q;
    sel_vl = axis_q ? view_top_q     : view_left_q;
    sel_vh = axis_q ? view_bottom_q  : view_right_q;
    wspan  = {sel_wh[15], sel_wh} - {sel_wl[15], sel_wl};
    vspan  = {sel_vh[15], sel_vh} - {sel_vl[15], sel_vl};
    wmag   = wspan[16] ? -wspan : wspan;
    vmag   = vspan[16] ? -vspan : vspan;

    cur_c      = axis_q ? y_q        : x_q;
    cur_scale  = axis_q ? scale_y_q  : scale_x_q;
    cur_offset = axis_q ? offset_y_q : offset_x_q;
    smag       = cur_scale[31] ? -cur_scale : cur_scale;

    case (state_q)
      S_MUL1: begin
        mul_a = {sel_vl[15], sel_vl};
        mul_b = {{16{sel_wh[15]}}, sel_wh};
      end
      S_MUL2: begin
        mul_a = {sel_wl[15], sel_wl};
        mul_b = {{16{sel_vh[15]}}, sel_vh};
      end
      default: begin
        mul_a = {1'b0, cur_c};
        mul_b = cur_scale;
      end
    endcase
    prod_d = mul_a * mul_b;

    // cross product of the edges; each product fits 31 bits plus sign
    onum = p1_q - prod_q[32:0];
    omag = onum[32] ? -onum : onum;

    fsh  = prod_q >>> wvt_pkg::FRAC_BITS;
    fsum = fsh[31:0] + ((cmd_q == wvt_pkg::CMD_PLACE) ? cur_offset : 32'd0);

    idiff = {18'd0, cur_c} - {{2{cur_offset[31]}}, cur_offset};
    imag  = idiff[33] ? -idiff : idiff;

    q32    = div_rsp.quo[31:0];
    qs     = sign_q ? -q32 : q32;
    qscale = (qs == 32'd0) ? 32'd1 : qs;
  end

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d        = state_q;
    axis_d         = axis_q;
    out_valid_d    = out_valid_q;
    world_left_d   = world_left_q;
    world_top_d    = world_top_q;
    world_right_d  = world_right_q;
    world_bottom_d = world_bottom_q;
    view_left_d    = view_left_q;
    view_top_d     = view_top_q;
    view_right_d   = view_right_q;
    view_bottom_d  = view_bottom_q;
    scale_x_d      = scale_x_q;
    scale_y_d      = scale_y_q;
    offset_x_d     = offset_x_q;
    offset_y_d     = offset_y_q;
    pen_x_d        = pen_x_q;
    pen_y_d        = pen_y_q;
    cmd_d          = cmd_q;
    x_d            = x_q;
    y_d            = y_q;
    sign_d         = sign_q;
    p1_d           = p1_q;
    res_x_d        = res_x_q;
    res_y_d        = res_y_q;
    out_x_d        = out_x_q;
    out_y_d        = out_y_q;
    start_x_d      = start_x_q;
    start_y_d      = start_y_q;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        wvt_pkg::REG_WORLD_LEFT:   world_left_d   = cfg_data_i;
        wvt_pkg::REG_WORLD_TOP:    world_top_d    = cfg_data_i;
        wvt_pkg::REG_WORLD_RIGHT:  world_right_d  = cfg_data_i;
        wvt_pkg::REG_WORLD_BOTTOM: world_bottom_d = cfg_data_i;
        wvt_pkg::REG_VIEW_LEFT:    view_left_d    = cfg_data_i;
        wvt_pkg::REG_VIEW_TOP:     view_top_d     = cfg_data_i;
        wvt_pkg::REG_VIEW_RIGHT:   view_right_d   = cfg_data_i;
        wvt_pkg::REG_VIEW_BOTTOM:  view_bottom_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d  = command_i;
          x_d    = x_in_i;
          y_d    = y_in_i;
          axis_d = 1'b0;
          case (command_i)
            wvt_pkg::CMD_MAP:   state_d = S_SPAN;
            wvt_pkg::CMD_PLACE: state_d = S_FMUL;
            wvt_pkg::CMD_SIZE:  state_d = S_FMUL;
            default:            state_d = S_IDIV;
          endcase
        end
      end
      S_SPAN: begin
        if (wspan == 17'd0) begin
          // degenerate world window: raw scale of one, no translation
          if (axis_q) begin
            scale_y_d  = 32'd1;
            offset_y_d = 32'd0;
            state_d    = S_OUT;
          end else begin
            scale_x_d  = 32'd1;
            offset_x_d = 32'd0;
            axis_d     = 1'b1;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = wvt_pkg::NUM_W'(vmag[15:0]) << wvt_pkg::FRAC_BITS;
          div_req.den   = wvt_pkg::DEN_W'(wmag[15:0]);
          sign_d        = vspan[16] ^ wspan[16];
          state_d       = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          if (axis_q) begin
            scale_y_d = qscale;
          end else begin
            scale_x_d = qscale;
          end
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p1_d    = prod_q[32:0];
        state_d = S_ODIV;
      end
      S_ODIV: begin
        div_req.start = 1'b1;
        div_req.num   = wvt_pkg::NUM_W'(omag[31:0]);
        div_req.den   = wvt_pkg::DEN_W'(wmag[15:0]);
        sign_d        = onum[32] ^ wspan[16];
        state_d       = S_OWAIT;
      end
      S_OWAIT: begin
        if (div_rsp.done) begin
          if (axis_q) begin
            offset_y_d = qs;
            state_d    = S_OUT;
          end else begin
            offset_x_d = qs;
            axis_d     = 1'b1;
            state_d    = S_SPAN;
          end
        end
      end
      S_FMUL: begin
        state_d = S_FADD;
      end
      S_FADD: begin
        if (axis_q) begin
          res_y_d = fsum;
          state_d = S_OUT;
        end else begin
          res_x_d = fsum;
          axis_d  = 1'b1;
          state_d = S_FMUL;
        end
      end
      S_IDIV: begin
        if (cur_scale == 32'd0) begin
          if (axis_q) begin
            res_y_d = 32'd0;
            state_d = S_OUT;
          end else begin
            res_x_d = 32'd0;
            axis_d  = 1'b1;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = wvt_pkg::NUM_W'(imag[31:0]) << wvt_pkg::FRAC_BITS;
          div_req.den   = smag;
          sign_d        = idiff[33] ^ cur_scale[31];
          state_d       = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (div_rsp.done) begin
          if (axis_q) begin
            res_y_d = qs;
            state_d = S_OUT;
          end else begin
            res_x_d = qs;
            axis_d  = 1'b1;
            state_d = S_IDIV;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_x_d     = (cmd_q == wvt_pkg::CMD_MAP) ? 32'd0 : res_x_q;
          out_y_d     = (cmd_q == wvt_pkg::CMD_MAP) ? 32'd0 : res_y_q;
          start_x_d   = pen_x_q;
          start_y_d   = pen_y_q;
          if (cmd_q == wvt_pkg::CMD_PLACE) begin
            pen_x_d = res_x_q[15:0];
            pen_y_d = res_y_q[15:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      axis_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      world_left_q   <= 16'd0;
      world_top_q    <= 16'd0;
      world_right_q  <= wvt_pkg::EDGE_RESET;
      world_bottom_q <= wvt_pkg::EDGE_RESET;
      view_left_q    <= 16'd0;
      view_top_q     <= 16'd0;
      view_right_q   <= wvt_pkg::EDGE_RESET;
      view_bottom_q  <= wvt_pkg::EDGE_RESET;
      scale_x_q      <= wvt_pkg::SCALE_ONE;
      scale_y_q      <= wvt_pkg::SCALE_ONE;
      offset_x_q     <= 32'd0;
      offset_y_q     <= 32'd0;
      pen_x_q        <= 16'd0;
      pen_y_q        <= 16'd0;
    end else begin
      state_q        <= state_d;
      axis_q         <= axis_d;
      out_valid_q    <= out_valid_d;
      world_left_q   <= world_left_d;
      world_top_q    <= world_top_d;
      world_right_q  <= world_right_d;
      world_bottom_q <= world_bottom_d;
      view_left_q    <= view_left_d;
      view_top_q     <= view_top_d;
      view_right_q   <= view_right_d;
      view_bottom_q  <= view_bottom_d;
      scale_x_q      <= scale_x_d;
      scale_y_q      <= scale_y_d;
      offset_x_q     <= offset_x_d;
      offset_y_q     <= offset_y_d;
      pen_x_q        <= pen_x_d;
      pen_y_q        <= pen_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    x_q       <= x_d;
    y_q       <= y_d;
    sign_q    <= sign_d;
    p1_q      <= p1_d;
    prod_q    <= prod_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    start_x_q <= start_x_d;
    start_y_q <= start_y_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign start_x_o   = start_x_q;
  assign start_y_o   = start_y_q;

`ifndef SYNTHESIS
  // a new result only ever comes out of the final sequencer step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

  // the divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_SDIV || state_q == S_OWAIT || state_q == S_IWAIT))
    else $error("divider result with no step waiting for it");

  // a zero scale is never stored
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_x_q != 32'd0) && (scale_y_q != 32'd0))
    else $error("zero scale stored");

  // the pen moves only when a place item completes
  a_pen_on_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pen_x_q) |-> $past(out_load && cmd_q == wvt_pkg::CMD_PLACE))
    else $error("pen changed outside a place item");
`endif

endmodule
